FILE: design/khm_pkg.sv
// shared types, constants and helper functions for the keypress heat map frame unit
`timescale 1ns / 1ps
`default_nettype none

package khm_pkg;

   // matrix size
   localparam int ROWS    = 4;
   localparam int COLUMNS = 8;
   localparam int LEDS    = ROWS * COLUMNS;

   // index widths, kept at least one bit wide
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int LED_W = (LEDS > 1) ? $clog2(LEDS) : 1;

   // field widths
   localparam int POS_W    = 3;
   localparam int COLOUR_W = 8;
   localparam int FRAC_W   = 16;
   localparam int SHADOW_W = COLOUR_W + FRAC_W;
   localparam int HUE_W    = 8;
   localparam int RGB_W    = 3 * COLOUR_W;
   localparam int SHADOW_RGB_W = 3 * SHADOW_W;

   // control register port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_SCALE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUE_STEP     = 2'd2;

   localparam logic [FRAC_W-1:0] DECAY_FACTOR_RESET = 16'd64881;
   localparam logic [FRAC_W-1:0] PRESS_SCALE_RESET  = 16'd39322;
   localparam logic [HUE_W-1:0]  HUE_STEP_RESET     = 8'd30;

   // colour wheel segment bounds
   localparam logic [HUE_W-1:0]    WHEEL_SEG1 = 8'd85;
   localparam logic [HUE_W-1:0]    WHEEL_SEG2 = 8'd170;
   localparam logic [COLOUR_W-1:0] FULL_ON    = 8'd255;

   // request payload
   typedef struct packed {
      logic             key_valid;
      logic [POS_W-1:0] key_row;
      logic [POS_W-1:0] key_column;
   } req_type;

   // response payload
   typedef struct packed {
      logic [POS_W-1:0]    led_row;
      logic [POS_W-1:0]    led_column;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
      logic                frame_last;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic             accept;
      logic             hue_update;
      logic             issue;
      logic [ROW_W-1:0] issue_row;
      logic [COL_W-1:0] issue_col;
      logic             issue_last;
      logic             s2_load;
      logic             out_load;
   } cmd_type;

   // flat led address of a row and column
   function automatic logic [LED_W-1:0] led_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
      return LED_W'(int'(row) * COLUMNS + int'(col));
   endfunction

   // three segment colour wheel, packed as red, green, blue
   function automatic logic [RGB_W-1:0] wheel(input logic [HUE_W-1:0] hue);
      logic [HUE_W-1:0]    off;
      logic [9:0]          h3;
      logic [COLOUR_W-1:0] r;
      logic [COLOUR_W-1:0] g;
      logic [COLOUR_W-1:0] b;
      if (hue < WHEEL_SEG1) begin
         off = hue;
      end else if (hue < WHEEL_SEG2) begin
         off = hue - WHEEL_SEG1;
      end else begin
         off = hue - WHEEL_SEG2;
      end
      h3 = 10'(off) * 10'd3;
      if (hue < WHEEL_SEG1) begin
         r = FULL_ON - h3[7:0];
         g = h3[7:0];
         b = '0;
      end else if (hue < WHEEL_SEG2) begin
         r = '0;
         g = FULL_ON - h3[7:0];
         b = h3[7:0];
      end else begin
         r = h3[7:0];
         g = '0;
         b = FULL_ON - h3[7:0];
      end
      return {r, g, b};
   endfunction

endpackage

`default_nettype wire

FILE: design/keypress_heat_map_frame_unit.sv
// top level of the keypress heat map frame unit
// a taken request passes the hue update, then the sweep issues each led through stage one,
// stage two and the response register; one led per cycle while rsp_ready keeps up,
// ROWS*COLUMNS results per frame; a new request is taken only after the previous frame's
// sweep has drained, as the single read port of the shadow store is walked once per frame
// reset: synchronous, clears hue and shadow stores through per-entry valid bits at once
// and loads the default control register values; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module keypress_heat_map_frame_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire khm_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output khm_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [khm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [khm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import khm_pkg::*;

   cmd_type cmd;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // frame sequencer
   khm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // stores and arithmetic
   khm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: design/khm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module khm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/khm_ctrl.sv
// frame sequencer: request handshake, led sweep counters and pipeline occupancy
`timescale 1ns / 1ps
`default_nettype none

module khm_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output khm_pkg::cmd_type      cmd
);
   import khm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_HUE   = 4'b0010,
      ST_SWEEP = 4'b0100,
      ST_DRAIN = 4'b1000
   } ctl_state_type;

   ctl_state_type    state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             v1_ff, v1_in;
   logic             v2_ff, v2_in;
   logic             out_valid_ff, out_valid_in;

   logic advance;
   logic accept;
   logic issue;
   logic last_led;

   // pipeline moves when the output register is free or being emptied
   assign advance  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept   = req_valid && req_ready;
   assign issue    = (state_ff == ST_SWEEP) && advance;
   assign last_led = (row_ff == ROW_W'(ROWS - 1)) && (col_ff == COL_W'(COLUMNS - 1));

   // state and sweep counters
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HUE;
               row_in   = '0;
               col_in   = '0;
            end
         end
         ST_HUE: begin
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (issue) begin
               if (last_led) begin
                  state_in = ST_DRAIN;
               end else if (col_ff == COL_W'(COLUMNS - 1)) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // pipeline occupancy
   always_comb begin
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         v1_in        = issue;
         v2_in        = v1_ff;
         out_valid_in = v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // commands to the datapath
   always_comb begin
      cmd.accept     = accept;
      cmd.hue_update = (state_ff == ST_HUE);
      cmd.issue      = issue;
      cmd.issue_row  = row_ff;
      cmd.issue_col  = col_ff;
      cmd.issue_last = last_led;
      cmd.s2_load    = advance && v1_ff;
      cmd.out_load   = advance && v2_ff;
   end

   assign rsp_valid = out_valid_ff;

   // hue update always hands over to the sweep
   a_hue_to_sweep: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HUE |=> state_ff == ST_SWEEP)
      else $error("hue update not followed by sweep");

   // no led in flight while waiting for a request
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !v1_ff && !v2_ff)
      else $error("pipeline busy while idle");

   // the last led of a frame ends the sweep
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      issue && last_led |=> state_ff == ST_DRAIN && v1_ff)
      else $error("sweep did not end after last led");

endmodule

`default_nettype wire

FILE: design/khm_datapath.sv
// hue and shadow stores, decay multipliers, colour wheel and response register
`timescale 1ns / 1ps
`default_nettype none

module khm_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire khm_pkg::cmd_type                    cmd,
   input  wire khm_pkg::req_type                    req_data,
   input  wire logic                                csr_valid,
   input  wire logic [khm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [khm_pkg::CSR_DATA_W-1:0]      csr_data,
   output khm_pkg::rsp_type                         rsp_data
);
   import khm_pkg::*;

   // control registers
   logic [FRAC_W-1:0] decay_ff;
   logic [FRAC_W-1:0] scale_ff;
   logic [HUE_W-1:0]  step_ff;

   // request latch
   logic             pressed_ff;
   logic [LED_W-1:0] press_addr_ff;

   // entry valid bits, cleared at reset
   logic [LEDS-1:0] hue_valid_ff;
   logic [LEDS-1:0] shadow_valid_ff;
   logic            hue_rd_valid_ff;
   logic            shadow_rd_valid_ff;

   // press colour and its shadow
   logic [RGB_W-1:0]        press_rgb_ff;
   logic [SHADOW_RGB_W-1:0] press_shadow_ff;

   // stage one: address issued to the shadow store
   logic [LED_W-1:0] s1_addr_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_last_ff;
   logic             s1_match_ff;

   // stage two: decayed shadow
   logic [LED_W-1:0]    s2_addr_ff;
   logic [ROW_W-1:0]    s2_row_ff;
   logic [COL_W-1:0]    s2_col_ff;
   logic                s2_last_ff;
   logic                s2_match_ff;
   logic [SHADOW_W-1:0] s2_red_ff;
   logic [SHADOW_W-1:0] s2_green_ff;
   logic [SHADOW_W-1:0] s2_blue_ff;

   rsp_type out_ff;

   logic                    req_in_range;
   logic [LED_W-1:0]        req_addr;
   logic [LED_W-1:0]        issue_addr;
   logic [HUE_W-1:0]        hue_rd;
   logic [HUE_W-1:0]        hue_new;
   logic [RGB_W-1:0]        hue_rgb;
   logic [SHADOW_RGB_W-1:0] shadow_rd;
   logic [SHADOW_RGB_W-1:0] shadow_cur;
   logic [SHADOW_W+FRAC_W-1:0] prod_red;
   logic [SHADOW_W+FRAC_W-1:0] prod_green;
   logic [SHADOW_W+FRAC_W-1:0] prod_blue;
   logic [SHADOW_RGB_W-1:0] shadow_wr;
   logic                    shadow_we;

   // control register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DECAY_FACTOR_RESET;
         scale_ff <= PRESS_SCALE_RESET;
         step_ff  <= HUE_STEP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DECAY_FACTOR: decay_ff <= csr_data;
            CSR_PRESS_SCALE:  scale_ff <= csr_data;
            CSR_HUE_STEP:     step_ff  <= csr_data[HUE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // press decode
   assign req_in_range = ({1'b0, req_data.key_row} < 4'(ROWS)) &&
                         ({1'b0, req_data.key_column} < 4'(COLUMNS));
   assign req_addr     = led_addr(ROW_W'(req_data.key_row), COL_W'(req_data.key_column));
   assign issue_addr   = led_addr(cmd.issue_row, cmd.issue_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= 1'b0;
      end else if (cmd.accept) begin
         pressed_ff <= req_data.key_valid && req_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         press_addr_ff   <= req_addr;
         hue_rd_valid_ff <= hue_valid_ff[req_addr];
      end
   end

   // hue store
   khm_ram #(
      .WIDTH (HUE_W),
      .DEPTH (LEDS)
   ) u_hue_ram (
      .clock   (clock),
      .wr_en   (cmd.hue_update && pressed_ff),
      .wr_addr (press_addr_ff),
      .wr_data (hue_new),
      .rd_en   (cmd.accept),
      .rd_addr (req_addr),
      .rd_data (hue_rd)
   );

   // hue advance and wheel colour
   assign hue_new = (hue_rd_valid_ff ? hue_rd : '0) + step_ff;
   assign hue_rgb = wheel(hue_new);

   always_ff @(posedge clock) begin
      if (cmd.hue_update) begin
         press_rgb_ff <= hue_rgb;
         press_shadow_ff <= {
            SHADOW_W'(hue_rgb[2*COLOUR_W +: COLOUR_W]) * SHADOW_W'(scale_ff),
            SHADOW_W'(hue_rgb[COLOUR_W +: COLOUR_W]) * SHADOW_W'(scale_ff),
            SHADOW_W'(hue_rgb[0 +: COLOUR_W]) * SHADOW_W'(scale_ff)
         };
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         hue_valid_ff    <= '0;
         shadow_valid_ff <= '0;
      end else begin
         if (cmd.hue_update && pressed_ff) begin
            hue_valid_ff[press_addr_ff] <= 1'b1;
         end
         if (shadow_we) begin
            shadow_valid_ff[s2_addr_ff] <= 1'b1;
         end
      end
   end

   // shadow store, red green blue side by side
   khm_ram #(
      .WIDTH (SHADOW_RGB_W),
      .DEPTH (LEDS)
   ) u_shadow_ram (
      .clock   (clock),
      .wr_en   (shadow_we),
      .wr_addr (s2_addr_ff),
      .wr_data (shadow_wr),
      .rd_en   (cmd.issue),
      .rd_addr (issue_addr),
      .rd_data (shadow_rd)
   );

   // stage one
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_addr_ff         <= issue_addr;
         s1_row_ff          <= cmd.issue_row;
         s1_col_ff          <= cmd.issue_col;
         s1_last_ff         <= cmd.issue_last;
         s1_match_ff        <= pressed_ff && (issue_addr == press_addr_ff);
         shadow_rd_valid_ff <= shadow_valid_ff[issue_addr];
      end
   end

   // decay multipliers
   assign shadow_cur = shadow_rd_valid_ff ? shadow_rd : '0;
   assign prod_red   = shadow_cur[2*SHADOW_W +: SHADOW_W] * decay_ff;
   assign prod_green = shadow_cur[SHADOW_W +: SHADOW_W] * decay_ff;
   assign prod_blue  = shadow_cur[0 +: SHADOW_W] * decay_ff;

   // stage two
   always_ff @(posedge clock) begin
      if (cmd.s2_load) begin
         s2_addr_ff  <= s1_addr_ff;
         s2_row_ff   <= s1_row_ff;
         s2_col_ff   <= s1_col_ff;
         s2_last_ff  <= s1_last_ff;
         s2_match_ff <= s1_match_ff;
         s2_red_ff   <= prod_red[FRAC_W +: SHADOW_W];
         s2_green_ff <= prod_green[FRAC_W +: SHADOW_W];
         s2_blue_ff  <= prod_blue[FRAC_W +: SHADOW_W];
      end
   end

   // shadow write back as the led leaves for the output register
   assign shadow_we = cmd.out_load;
   assign shadow_wr = s2_match_ff ? press_shadow_ff : {s2_red_ff, s2_green_ff, s2_blue_ff};

   // response register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.led_row    <= POS_W'(s2_row_ff);
         out_ff.led_column <= POS_W'(s2_col_ff);
         out_ff.frame_last <= s2_last_ff;
         if (s2_match_ff) begin
            out_ff.red   <= press_rgb_ff[2*COLOUR_W +: COLOUR_W];
            out_ff.green <= press_rgb_ff[COLOUR_W +: COLOUR_W];
            out_ff.blue  <= press_rgb_ff[0 +: COLOUR_W];
         end else begin
            out_ff.red   <= s2_red_ff[FRAC_W +: COLOUR_W];
            out_ff.green <= s2_green_ff[FRAC_W +: COLOUR_W];
            out_ff.blue  <= s2_blue_ff[FRAC_W +: COLOUR_W];
         end
      end
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire

FILE: test/keypress_heat_map_frame_checker.sv
// channel monitor, frame colour predictor and led comparator for the heat map frame unit
`timescale 1ns / 1ps

module keypress_heat_map_frame_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_ready,
   input  wire khm_pkg::req_type                 req_data,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire khm_pkg::rsp_type                 rsp_data,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [khm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [khm_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                                    fault_count,
   output int                                    pending_leds
);
   import khm_pkg::*;

   // predicted led store and key hues
   logic [SHADOW_W-1:0] shade_red   [ROWS][COLUMNS];
   logic [SHADOW_W-1:0] shade_green [ROWS][COLUMNS];
   logic [SHADOW_W-1:0] shade_blue  [ROWS][COLUMNS];
   logic [HUE_W-1:0]    hue_of_key  [ROWS][COLUMNS];

   // predicted control registers
   logic [FRAC_W-1:0] decay_q;
   logic [FRAC_W-1:0] scale_q;
   logic [HUE_W-1:0]  step_q;

   // led colours still owed by the block, oldest first
   rsp_type led_colours_due[$];
   rsp_type due;

   initial begin
      fault_count  = 0;
      pending_leds = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      fault_count++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // one frame's decay with truncation, Q8.16 times Q0.16
   function automatic logic [SHADOW_W-1:0] decayed(input logic [SHADOW_W-1:0] s);
      logic [SHADOW_W+FRAC_W-1:0] prod;
      prod = (SHADOW_W+FRAC_W)'(s) * (SHADOW_W+FRAC_W)'(decay_q);
      return prod[SHADOW_W+FRAC_W-1:FRAC_W];
   endfunction

   // three segment colour wheel
   function automatic void wheel_colour(input logic [HUE_W-1:0] h,
                                        output int r, output int g, output int b);
      int hv;
      hv = int'(h);
      if (hv < int'(WHEEL_SEG1)) begin
         r = int'(FULL_ON) - 3 * hv;
         g = 3 * hv;
         b = 0;
      end else if (hv < int'(WHEEL_SEG2)) begin
         r = 0;
         g = int'(FULL_ON) - 3 * (hv - int'(WHEEL_SEG1));
         b = 3 * (hv - int'(WHEEL_SEG1));
      end else begin
         r = 3 * (hv - int'(WHEEL_SEG2));
         g = 0;
         b = int'(FULL_ON) - 3 * (hv - int'(WHEEL_SEG2));
      end
   endfunction

   // advance the predicted frame by one tick and queue every led it sends out
   task automatic advance_frame(input req_type tick);
      logic             hit;
      logic [HUE_W-1:0] h;
      int               pr;
      int               pg;
      int               pb;
      rsp_type          led;
      pr = 0;
      pg = 0;
      pb = 0;
      for (int i = 0; i < ROWS; i++) begin
         for (int j = 0; j < COLUMNS; j++) begin
            shade_red[i][j]   = decayed(shade_red[i][j]);
            shade_green[i][j] = decayed(shade_green[i][j]);
            shade_blue[i][j]  = decayed(shade_blue[i][j]);
         end
      end
      // presses outside the matrix only decay
      hit = tick.key_valid && int'(tick.key_row) < ROWS && int'(tick.key_column) < COLUMNS;
      if (hit) begin
         h = hue_of_key[tick.key_row][tick.key_column] + step_q;
         hue_of_key[tick.key_row][tick.key_column] = h;
         wheel_colour(h, pr, pg, pb);
         shade_red[tick.key_row][tick.key_column]   = SHADOW_W'(pr * scale_q);
         shade_green[tick.key_row][tick.key_column] = SHADOW_W'(pg * scale_q);
         shade_blue[tick.key_row][tick.key_column]  = SHADOW_W'(pb * scale_q);
      end
      // row-major sweep, pressed led shows the full wheel colour
      for (int i = 0; i < ROWS; i++) begin
         for (int j = 0; j < COLUMNS; j++) begin
            led.led_row    = POS_W'(i);
            led.led_column = POS_W'(j);
            if (hit && i == int'(tick.key_row) && j == int'(tick.key_column)) begin
               led.red   = COLOUR_W'(pr);
               led.green = COLOUR_W'(pg);
               led.blue  = COLOUR_W'(pb);
            end else begin
               led.red   = shade_red[i][j][SHADOW_W-1:FRAC_W];
               led.green = shade_green[i][j][SHADOW_W-1:FRAC_W];
               led.blue  = shade_blue[i][j][SHADOW_W-1:FRAC_W];
            end
            led.frame_last = (i == ROWS - 1) && (j == COLUMNS - 1);
            led_colours_due.push_back(led);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS; i++) begin
            for (int j = 0; j < COLUMNS; j++) begin
               shade_red[i][j]   = '0;
               shade_green[i][j] = '0;
               shade_blue[i][j]  = '0;
               hue_of_key[i][j]  = '0;
            end
         end
         decay_q = DECAY_FACTOR_RESET;
         scale_q = PRESS_SCALE_RESET;
         step_q  = HUE_STEP_RESET;
         led_colours_due.delete();
         pending_leds = 0;
      end else begin
         // register writes, unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DECAY_FACTOR: decay_q = csr_data;
               CSR_PRESS_SCALE:  scale_q = csr_data;
               CSR_HUE_STEP:     step_q  = csr_data[HUE_W-1:0];
               default: ;
            endcase
         end
         // compare each led request with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (led_colours_due.size() == 0) begin
               report_mismatch("led request with nothing expected", int'(rsp_data), 0);
            end else begin
               due = led_colours_due.pop_front();
               if (rsp_data.led_row !== due.led_row)
                  report_mismatch("led_row", rsp_data.led_row, due.led_row);
               if (rsp_data.led_column !== due.led_column)
                  report_mismatch("led_column", rsp_data.led_column, due.led_column);
               if (rsp_data.red !== due.red)
                  report_mismatch($sformatf("red of led %0d,%0d", due.led_row, due.led_column),
                                  rsp_data.red, due.red);
               if (rsp_data.green !== due.green)
                  report_mismatch($sformatf("green of led %0d,%0d", due.led_row, due.led_column),
                                  rsp_data.green, due.green);
               if (rsp_data.blue !== due.blue)
                  report_mismatch($sformatf("blue of led %0d,%0d", due.led_row, due.led_column),
                                  rsp_data.blue, due.blue);
               if (rsp_data.frame_last !== due.frame_last)
                  report_mismatch("frame_last", rsp_data.frame_last, due.frame_last);
            end
         end
         if (req_valid && req_ready)
            advance_frame(req_data);
         pending_leds = led_colours_due.size();
      end
   end

endmodule

FILE: test/keypress_heat_map_frame_unit_test.sv
// stimulus, handshake pacing and verdict for the keypress heat map frame unit
`timescale 1ns / 1ps

module keypress_heat_map_frame_unit_test;
   import khm_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = CSR_INDEX_W'(3);
   localparam int RANDOM_TICKS    = 44;
   localparam int SETTLE_CYCLES   = 12;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int   fault_count;
   int   pending_leds;
   int   tx_idle_pct = 35;
   int   rx_idle_pct = 58;
   logic hold_off_request = 1'b0;
   int   hold_off_left = 0;
   int   stall_cycles = 0;

   always #5 clock = ~clock;

   keypress_heat_map_frame_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   keypress_heat_map_frame_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fault_count  (fault_count),
      .pending_leds (pending_leds)
   );

   // led receiver: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_off_left    = HOLD_OFF_CYCLES;
         hold_off_request = 1'b0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // watchdog on cycles with no request moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic req_type make_tick(input logic v, input int row, input int col);
      req_type t;
      t.key_valid  = v;
      t.key_row    = POS_W'(row);
      t.key_column = POS_W'(col);
      return t;
   endfunction

   // mostly in-range presses, some idle ticks and some presses off the matrix
   function automatic req_type random_tick();
      int kind;
      kind = $urandom_range(99);
      if (kind < 10)
         return make_tick(1'b0, $urandom_range(7), $urandom_range(7));
      if (kind < 20)
         return make_tick(1'b1, $urandom_range(7, ROWS), $urandom_range(7));
      return make_tick(1'b1, $urandom_range(ROWS - 1), $urandom_range(COLUMNS - 1));
   endfunction

   // Q0.16 value, weighted to slow decay with the extremes now and then
   function automatic logic [CSR_DATA_W-1:0] pick_q16();
      int kind;
      kind = $urandom_range(9);
      if (kind == 0)
         return '0;
      if (kind == 1)
         return '1;
      if (kind < 6)
         return CSR_DATA_W'($urandom_range(65535, 49152));
      return CSR_DATA_W'($urandom_range(65535));
   endfunction

   // offer one tick, called and returning at a falling edge
   task automatic send_tick(input req_type tick);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= tick;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // stop offering and wait until every led of every frame has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_leds != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // registers are only touched with the block idle
   task automatic program_regs(input logic [CSR_DATA_W-1:0] decay,
                               input logic [CSR_DATA_W-1:0] scale,
                               input logic [HUE_W-1:0] step);
      settle();
      write_reg(CSR_DECAY_FACTOR, decay);
      write_reg(CSR_PRESS_SCALE, scale);
      write_reg(CSR_HUE_STEP, CSR_DATA_W'(step));
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom_range(65535)));
      csr_valid <= 1'b0;
   endtask

   task automatic random_ticks();
      repeat (RANDOM_TICKS) send_tick(random_tick());
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default registers: corners, repeat press, idle ticks, presses off the matrix
      send_tick(make_tick(1'b1, 0, 0));
      send_tick(make_tick(1'b1, 0, 0));
      send_tick(make_tick(1'b1, ROWS - 1, COLUMNS - 1));
      send_tick(make_tick(1'b0, 7, 7));
      send_tick(make_tick(1'b1, ROWS, 0));
      send_tick(make_tick(1'b1, 7, 7));
      send_tick(make_tick(1'b0, 0, 0));
      send_tick(make_tick(1'b1, 2, 3));

      // full decay and scale, hue steps across every wheel segment and wraps
      program_regs('1, '1, HUE_W'(85));
      repeat (4) send_tick(make_tick(1'b1, 1, 1));
      send_tick(make_tick(1'b0, 5, 2));

      // zero decay clears every shadow, zero scale, hue step that wraps
      program_regs('0, '0, '1);
      send_tick(make_tick(1'b1, 1, 1));
      send_tick(make_tick(1'b1, 3, 0));
      send_tick(make_tick(1'b0, 0, 7));
      send_tick(make_tick(1'b1, 6, 6));

      // half decay, smallest nonzero scale, zero hue step
      program_regs(CSR_DATA_W'(32768), CSR_DATA_W'(1), '0);
      send_tick(make_tick(1'b1, 0, 0));
      send_tick(make_tick(1'b1, 0, 0));

      // random frames under each idling pattern
      program_regs(pick_q16(), pick_q16(), HUE_W'($urandom_range(255)));
      random_ticks();

      settle();
      tx_idle_pct = 58;
      rx_idle_pct = 35;
      program_regs(pick_q16(), pick_q16(), HUE_W'($urandom_range(255)));
      random_ticks();

      settle();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      program_regs(DECAY_FACTOR_RESET, PRESS_SCALE_RESET, HUE_STEP_RESET);
      // receiver backs off while ticks keep coming, so the block fills and stalls
      hold_off_request = 1'b1;
      random_ticks();

      settle();
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/khm_pkg.sv
design/khm_ram.sv
design/khm_ctrl.sv
design/khm_datapath.sv
design/keypress_heat_map_frame_unit.sv
test/keypress_heat_map_frame_checker.sv
test/keypress_heat_map_frame_unit_test.sv
